// ===== sv/altok_pkg.sv =====
// ============================================================================
// altok_pkg
// Shared types, character classes and status codes for the assembler line
// tokenizer.
// ============================================================================
`default_nettype none

package altok_pkg;

    // character classes, worked out in the front part
    typedef logic [2:0] cls_t;
    localparam cls_t CL_OTHER = 3'd0;
    localparam cls_t CL_BLANK = 3'd1;
    localparam cls_t CL_COMMA = 3'd2;
    localparam cls_t CL_LBR   = 3'd3;
    localparam cls_t CL_RBR   = 3'd4;
    localparam cls_t CL_DIGIT = 3'd5;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_BRACKET = 2'd1;
    localparam status_t ST_LONG    = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic       eol;    // end marker beat
        logic       over;   // character beyond the line length
        cls_t       cls;
        logic [3:0] digit;  // low nibble of the character
        logic [7:0] pos;    // position, taken modulo 256
    } tok_item_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r = CL_OTHER;
        if (c == 8'h20 || c == 8'h09)
            r = CL_BLANK;
        else if (c == 8'h2C)
            r = CL_COMMA;
        else if (c == 8'h5B)
            r = CL_LBR;
        else if (c == 8'h5D)
            r = CL_RBR;
        else if (c >= 8'h30 && c <= 8'h39)
            r = CL_DIGIT;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/altok_front.sv =====
// ============================================================================
// altok_front
// Input side: counts positions, flags overlong lines and classifies each
// character before it enters the queue.
// ============================================================================
`default_nettype none

module altok_front
    import altok_pkg::*;
#(
    parameter int LINE_LEN = 256
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [7:0] ch,
    input  wire logic      end_of_line,
    input  wire logic      q_ready,
    output logic           push,
    output tok_item_t      push_item
);

    localparam int POS_W = $clog2(LINE_LEN + 1);
    localparam int EXT_W = POS_W + 8;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [EXT_W-1:0] pos_ext;
    logic             at_limit;

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;
    assign at_limit = (pos_reg >= POS_W'(LINE_LEN));
    assign pos_ext  = EXT_W'(pos_reg);

    always_comb
    begin
        push_item.eol   = end_of_line;
        push_item.over  = at_limit;
        push_item.cls   = classify(ch);
        push_item.digit = ch[3:0];
        push_item.pos   = pos_ext[7:0];
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (end_of_line)
                pos_next = '0;
            else if (!at_limit)
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

// ===== sv/altok_fifo.sv =====
// ============================================================================
// altok_fifo
// Short queue of classified beats between front and back.
// ============================================================================
`default_nettype none

module altok_fifo
    import altok_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  tok_item_t  push_item,
    output logic       q_ready,
    output logic       q_valid,
    output tok_item_t  q_item,
    input  wire logic  pop
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(QUEUE_DEPTH)) |-> !push)
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== sv/altok_back.sv =====
// ============================================================================
// altok_back
// Tokenizer FSM and result register; one queued beat per cycle unless stalled.
// ============================================================================
`default_nettype none

module altok_back
    import altok_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  tok_item_t   q_item,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        line_empty,
    output logic [7:0]  name_start,
    output logic [8:0]  name_len,
    output logic [6:0]  repeat_value,
    output logic [1:0]  op_count,
    output logic [7:0]  op_a_start,
    output logic [8:0]  op_a_len,
    output logic [7:0]  op_b_start,
    output logic [8:0]  op_b_len,
    output logic [7:0]  op_c_start,
    output logic [8:0]  op_c_len,
    output status_t     status
);

    localparam logic [2:0] PH_LEAD    = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_BRACKET = 3'd2;
    localparam logic [2:0] PH_GAP     = 3'd3;
    localparam logic [2:0] PH_OPER    = 3'd4;
    localparam logic [2:0] PH_SEP     = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [1:0] MAX_OPS = 2'd3;

    // tokenizer state
    logic [2:0] phase_reg, phase_next;
    logic [7:0] mstart_reg, mstart_next;
    logic [8:0] mlen_reg, mlen_next;
    logic [6:0] racc_reg, racc_next;
    logic [1:0] rseen_reg, rseen_next;
    logic       rdone_reg, rdone_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] ostart_reg [3];
    logic [7:0] ostart_next [3];
    logic [8:0] olen_reg [3];
    logic [8:0] olen_next [3];
    status_t    err_reg, err_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       empty_reg, empty_next;
    logic [7:0] rs_start_reg, rs_start_next;
    logic [8:0] rs_len_reg, rs_len_next;
    logic [6:0] rs_rep_reg, rs_rep_next;
    logic [1:0] rs_cnt_reg, rs_cnt_next;
    logic [7:0] rs_ostart_reg [3];
    logic [7:0] rs_ostart_next [3];
    logic [8:0] rs_olen_reg [3];
    logic [8:0] rs_olen_next [3];
    status_t    rs_status_reg, rs_status_next;

    logic       is_blank, is_comma, is_sep;
    logic [1:0] idx_inc;
    logic [6:0] racc_x10;

    assign is_blank = (q_item.cls == CL_BLANK);
    assign is_comma = (q_item.cls == CL_COMMA);
    assign is_sep   = is_blank || is_comma;
    assign idx_inc  = (idx_reg < MAX_OPS) ? idx_reg + 2'd1 : idx_reg;
    assign racc_x10 = (racc_reg << 3) + (racc_reg << 1);

    // an end beat waits until the result register is free
    assign pop = q_valid && (!q_item.eol || !out_valid_reg || out_ready);

    always_comb
    begin
        phase_next  = phase_reg;
        mstart_next = mstart_reg;
        mlen_next   = mlen_reg;
        racc_next   = racc_reg;
        rseen_next  = rseen_reg;
        rdone_next  = rdone_reg;
        idx_next    = idx_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        err_next    = err_reg;

        out_valid_next = out_valid_reg && !out_ready;
        empty_next     = empty_reg;
        rs_start_next  = rs_start_reg;
        rs_len_next    = rs_len_reg;
        rs_rep_next    = rs_rep_reg;
        rs_cnt_next    = rs_cnt_reg;
        rs_ostart_next = rs_ostart_reg;
        rs_olen_next   = rs_olen_reg;
        rs_status_next = rs_status_reg;

        if (pop)
        begin
            if (q_item.eol)
            begin
                out_valid_next = 1'b1;
                empty_next     = (phase_reg == PH_LEAD);
                rs_start_next  = '0;
                rs_len_next    = '0;
                rs_rep_next    = '0;
                rs_cnt_next    = '0;
                rs_status_next = err_reg;
                for (int k = 0; k < 3; k++)
                begin
                    rs_ostart_next[k] = '0;
                    rs_olen_next[k]   = '0;
                end
                if (phase_reg != PH_LEAD)
                begin
                    rs_start_next = mstart_reg;
                    rs_len_next   = mlen_reg;
                    rs_rep_next   = racc_reg;
                    if (phase_reg == PH_BRACKET)
                    begin
                        if (err_reg == ST_OK)
                            rs_status_next = ST_BRACKET;
                    end
                    else
                    begin
                        rs_cnt_next = idx_reg;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (2'(k) < idx_reg)
                            begin
                                rs_ostart_next[k] = ostart_reg[k];
                                rs_olen_next[k]   = olen_reg[k];
                            end
                        end
                    end
                end
                // fresh line
                phase_next  = PH_LEAD;
                mstart_next = '0;
                mlen_next   = '0;
                racc_next   = '0;
                rseen_next  = '0;
                rdone_next  = 1'b0;
                idx_next    = '0;
                err_next    = ST_OK;
                for (int k = 0; k < 3; k++)
                begin
                    ostart_next[k] = '0;
                    olen_next[k]   = '0;
                end
            end
            else if (q_item.over)
            begin
                err_next = ST_LONG;
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (!is_blank)
                        begin
                            mstart_next = q_item.pos;
                            if (q_item.cls == CL_LBR)
                            begin
                                mlen_next  = '0;
                                phase_next = PH_BRACKET;
                            end
                            else
                            begin
                                mlen_next  = 9'd1;
                                phase_next = PH_NAME;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        if (is_blank)
                            phase_next = PH_GAP;
                        else if (q_item.cls == CL_LBR)
                            phase_next = PH_BRACKET;
                        else
                            mlen_next = mlen_reg + 9'd1;
                    end
                    PH_BRACKET:
                    begin
                        if (q_item.cls == CL_RBR)
                            phase_next = PH_GAP;
                        else if (rseen_reg < 2'd2)
                        begin
                            rseen_next = rseen_reg + 2'd1;
                            if (!rdone_reg && q_item.cls == CL_DIGIT)
                                racc_next = racc_x10 + 7'(q_item.digit);
                            else
                                rdone_next = 1'b1;
                        end
                    end
                    PH_GAP, PH_SEP:
                    begin
                        // a comma straight after the gap is an empty operand
                        if (!is_blank && !(phase_reg == PH_SEP && is_comma))
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (idx_reg == 2'(k))
                                begin
                                    ostart_next[k] = q_item.pos;
                                    olen_next[k]   = is_comma ? 9'd0 : 9'd1;
                                end
                            end
                            idx_next = idx_inc;
                            if (is_comma)
                                phase_next = (idx_inc == MAX_OPS) ? PH_DONE : PH_SEP;
                            else
                                phase_next = PH_OPER;
                        end
                    end
                    PH_OPER:
                    begin
                        if (is_sep)
                            phase_next = (idx_reg == MAX_OPS) ? PH_DONE : PH_SEP;
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (idx_reg == 2'(k + 1))
                                    olen_next[k] = olen_reg[k] + 9'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            mstart_reg    <= '0;
            mlen_reg      <= '0;
            racc_reg      <= '0;
            rseen_reg     <= '0;
            rdone_reg     <= 1'b0;
            idx_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                ostart_reg[k] <= '0;
                olen_reg[k]   <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            mstart_reg    <= mstart_next;
            mlen_reg      <= mlen_next;
            racc_reg      <= racc_next;
            rseen_reg     <= rseen_next;
            rdone_reg     <= rdone_next;
            idx_reg       <= idx_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            ostart_reg    <= ostart_next;
            olen_reg      <= olen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg     <= empty_next;
        rs_start_reg  <= rs_start_next;
        rs_len_reg    <= rs_len_next;
        rs_rep_reg    <= rs_rep_next;
        rs_cnt_reg    <= rs_cnt_next;
        rs_ostart_reg <= rs_ostart_next;
        rs_olen_reg   <= rs_olen_next;
        rs_status_reg <= rs_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign line_empty   = empty_reg;
    assign name_start   = rs_start_reg;
    assign name_len     = rs_len_reg;
    assign repeat_value = rs_rep_reg;
    assign op_count     = rs_cnt_reg;
    assign op_a_start   = rs_ostart_reg[0];
    assign op_a_len     = rs_olen_reg[0];
    assign op_b_start   = rs_ostart_reg[1];
    assign op_b_len     = rs_olen_reg[1];
    assign op_c_start   = rs_ostart_reg[2];
    assign op_c_len     = rs_olen_reg[2];
    assign status       = rs_status_reg;

    a_eol_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_item.eol && out_valid_reg && !out_ready) |-> !pop)
        else $error("end beat taken over an unread result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.eol) |=> out_valid_reg)
        else $error("end beat gave no result");

    a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |->
            (rs_len_reg == '0 && rs_cnt_reg == '0 && rs_status_reg != ST_BRACKET))
        else $error("empty line reports tokens");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEP) |-> (idx_reg != MAX_OPS))
        else $error("separator phase with all operand slots used");

endmodule

`default_nettype wire

// ===== sv/asm_line_tokenizer_unit.sv =====
// ============================================================================
// asm_line_tokenizer_unit
// Splits an assembler source line, streamed one character per beat, into a
// mnemonic, an optional repeat modifier and up to three operands.
// ============================================================================
//
//  Channel  Handshake             Payload                       Beats
//  -------  --------------------  ----------------------------  --------------
//  in       in_valid / in_ready   ch, end_of_line               one per char,
//                                                               one end marker
//  out      out_valid / out_ready line_empty .. status          one per line
//
//  Cycles : one beat per cycle in steady state. A beat is classified in the
//           front, written to the queue memory, then popped by the back state
//           machine; out_valid rises in the cycle after the end marker pops.
//  Reset  : rst_n clears position, queue pointers, tokenizer state and the
//           result valid; no clearing pass is needed.
//  Stalls : the back stops only at an end marker while an unread result sits
//           in the output register; the four-beat queue absorbs the front
//           meanwhile, and in_ready falls when the queue fills.
//
`default_nettype none

module asm_line_tokenizer_unit
    import altok_pkg::*;
#(
    parameter int LINE_LEN = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_line,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            line_empty,
    output logic [7:0]      name_start,
    output logic [8:0]      name_len,
    output logic [6:0]      repeat_value,
    output logic [1:0]      op_count,
    output logic [7:0]      op_a_start,
    output logic [8:0]      op_a_len,
    output logic [7:0]      op_b_start,
    output logic [8:0]      op_b_len,
    output logic [7:0]      op_c_start,
    output logic [8:0]      op_c_len,
    output logic [1:0]      status
);

    logic      push;
    tok_item_t push_item;
    logic      q_ready;
    logic      q_valid;
    tok_item_t q_item;
    logic      pop;

    // front: position count, overlong flag, character class
    altok_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .end_of_line (end_of_line),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    altok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // back: tokenizer state machine and result register
    altok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_empty   (line_empty),
        .name_start   (name_start),
        .name_len     (name_len),
        .repeat_value (repeat_value),
        .op_count     (op_count),
        .op_a_start   (op_a_start),
        .op_a_len     (op_a_len),
        .op_b_start   (op_b_start),
        .op_b_len     (op_b_len),
        .op_c_start   (op_c_start),
        .op_c_len     (op_c_len),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for asm_line_tokenizer_unit. Lines of characters are
// streamed in beat by beat. A line tracker works out the tokens of each line
// in parallel and checks every result beat against the oldest line waiting.
// ============================================================================

import altok_pkg::*;

localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_COMMA = 8'h2C;
localparam logic [7:0] CH_LBR   = 8'h5B;
localparam logic [7:0] CH_RBR   = 8'h5D;
localparam logic [7:0] CH_ZERO  = 8'h30;
localparam logic [7:0] CH_NINE  = 8'h39;

// where the tracker is within the line
typedef enum logic [2:0] {
    TP_LEAD,
    TP_NAME,
    TP_BRACKET,
    TP_GAP,
    TP_OPER,
    TP_SEP,
    TP_DONE
} tok_phase_e;

typedef struct packed {
    logic            line_empty;
    logic [7:0]      name_start;
    logic [8:0]      name_len;
    logic [6:0]      repeat_value;
    logic [1:0]      op_count;
    logic [2:0][7:0] op_start;
    logic [2:0][8:0] op_len;
    status_t         status;
} line_tokens_t;

// Tracks the line being streamed and holds the tokens of finished lines
// until the block reports them.
class token_tracker;
    int           line_len;
    tok_phase_e   phase;
    int           pos;
    logic [7:0]   name_at;
    logic [8:0]   name_chars;
    int           rep_acc;
    int           rep_seen;
    bit           rep_stop;
    int           ops;
    logic [7:0]   op_at [3];
    logic [8:0]   op_chars [3];
    status_t      err;
    line_tokens_t expected_lines [$];
    int           mismatches;
    int           lines_checked;

    function new(int len);
        line_len      = len;
        mismatches    = 0;
        lines_checked = 0;
        restart();
    endfunction

    function void restart();
        phase      = TP_LEAD;
        pos        = 0;
        name_at    = '0;
        name_chars = '0;
        rep_acc    = 0;
        rep_seen   = 0;
        rep_stop   = 0;
        ops        = 0;
        err        = ST_OK;
        for (int k = 0; k < 3; k++)
        begin
            op_at[k]    = '0;
            op_chars[k] = '0;
        end
    endfunction

    function bit blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function void open_operand(int p, int len);
        if (ops < 3)
        begin
            op_at[ops]    = p[7:0];
            op_chars[ops] = len[8:0];
            ops++;
        end
    endfunction

    function void end_operand();
        phase = (ops >= 3) ? TP_DONE : TP_SEP;
    endfunction

    function int pending();
        return expected_lines.size();
    endfunction

    // one accepted input beat
    function void note_beat(logic [7:0] c, logic last);
        line_tokens_t want;
        status_t      st;
        if (!last)
        begin
            if (pos >= line_len)
            begin
                err = ST_LONG;
                return;
            end
            case (phase)
                TP_LEAD:
                    if (!blank(c))
                    begin
                        name_at = pos[7:0];
                        if (c == CH_LBR)
                        begin
                            name_chars = '0;
                            phase      = TP_BRACKET;
                        end
                        else
                        begin
                            name_chars = 9'd1;
                            phase      = TP_NAME;
                        end
                    end
                TP_NAME:
                    if (blank(c))
                        phase = TP_GAP;
                    else if (c == CH_LBR)
                        phase = TP_BRACKET;
                    else
                        name_chars++;
                TP_BRACKET:
                    if (c == CH_RBR)
                        phase = TP_GAP;
                    else if (rep_seen < 2)
                    begin
                        // only the first two characters count
                        rep_seen++;
                        if (!rep_stop && c >= CH_ZERO && c <= CH_NINE)
                            rep_acc = rep_acc * 10 + int'(c - CH_ZERO);
                        else
                            rep_stop = 1;
                    end
                TP_GAP:
                    if (!blank(c))
                    begin
                        if (c == CH_COMMA)
                        begin
                            // empty operand at the comma
                            open_operand(pos, 0);
                            end_operand();
                        end
                        else
                        begin
                            open_operand(pos, 1);
                            phase = TP_OPER;
                        end
                    end
                TP_OPER:
                    if (blank(c) || c == CH_COMMA)
                        end_operand();
                    else if (ops >= 1)
                        op_chars[ops - 1]++;
                TP_SEP:
                    if (!(blank(c) || c == CH_COMMA))
                    begin
                        open_operand(pos, 1);
                        phase = TP_OPER;
                    end
                default:
                    ;
            endcase
            pos++;
            return;
        end

        want = '0;
        st   = err;
        if (phase == TP_LEAD)
            want.line_empty = 1'b1;
        else
        begin
            want.name_start   = name_at;
            want.name_len     = name_chars;
            want.repeat_value = rep_acc[6:0];
            if (phase == TP_BRACKET && st == ST_OK)
                st = ST_BRACKET;
            if (phase != TP_BRACKET)
            begin
                want.op_count = ops[1:0];
                for (int k = 0; k < ops; k++)
                begin
                    want.op_start[k] = op_at[k];
                    want.op_len[k]   = op_chars[k];
                end
            end
        end
        want.status = st;
        expected_lines.push_back(want);
        restart();
    endfunction

    function void field(string what, logic [8:0] want_v, logic [8:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("line %0d: %s expected %0d, got %0d",
                         lines_checked, what, want_v, got_v);
        end
    endfunction

    // one accepted result beat
    function void check_line(line_tokens_t got);
        line_tokens_t want;
        if (expected_lines.size() == 0)
        begin
            field("out_valid with no line pending", 9'd0, 9'd1);
            return;
        end
        want = expected_lines.pop_front();
        field("line_empty", 9'(want.line_empty), 9'(got.line_empty));
        field("name_start", 9'(want.name_start), 9'(got.name_start));
        field("name_len", want.name_len, got.name_len);
        field("repeat_value", 9'(want.repeat_value), 9'(got.repeat_value));
        field("op_count", 9'(want.op_count), 9'(got.op_count));
        for (int k = 0; k < 3; k++)
        begin
            field($sformatf("op%0d_start", k), 9'(want.op_start[k]),
                  9'(got.op_start[k]));
            field($sformatf("op%0d_len", k), want.op_len[k], got.op_len[k]);
        end
        field("status", 9'(want.status), 9'(got.status));
        lines_checked++;
    endfunction
endclass

module testbench;

    localparam int LINE_LEN     = 256;
    localparam int RANDOM_BEATS = 900;   // character and end beats after the directed lines
    localparam int HOLD_CYCLES  = 150;   // long output hold-off
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] ch;
    logic       end_of_line;
    logic       out_valid;
    logic       out_ready;
    logic       line_empty;
    logic [7:0] name_start;
    logic [8:0] name_len;
    logic [6:0] repeat_value;
    logic [1:0] op_count;
    logic [7:0] op_a_start;
    logic [8:0] op_a_len;
    logic [7:0] op_b_start;
    logic [8:0] op_b_len;
    logic [7:0] op_c_start;
    logic [8:0] op_c_len;
    status_t    status;

    token_tracker tracker;
    logic [7:0]   line_buf [$];      // characters of the next line
    bit           idle_on = 1'b1;    // random idling on both sides
    bit           hold_req = 1'b0;   // asks the receiver for a long hold-off
    int           quiet_cycles = 0;

    asm_line_tokenizer_unit #(.LINE_LEN(LINE_LEN)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_line  (end_of_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_empty   (line_empty),
        .name_start   (name_start),
        .name_len     (name_len),
        .repeat_value (repeat_value),
        .op_count     (op_count),
        .op_a_start   (op_a_start),
        .op_a_len     (op_a_len),
        .op_b_start   (op_b_start),
        .op_b_len     (op_b_len),
        .op_c_start   (op_c_start),
        .op_c_len     (op_c_len),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // character pickers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_COMMA;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    // a character that neither ends a mnemonic nor an operand
    function automatic logic [7:0] pick_word();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h61, 8'h7A));
        do
            c = 8'($urandom);
        while (c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_LBR);
        return c;
    endfunction

    task automatic load_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // ------------------------------------------------------------------
    // input side: one beat, with a random idle burst in front of it.
    // Entered and left at a falling edge; valid stays up between beats.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] c, input logic last);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= c;
        end_of_line <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_beat(c, last);
        @(negedge clk);
    endtask

    // the buffered line, then its end beat with a junk character
    task automatic send_line();
        foreach (line_buf[i])
            send_beat(line_buf[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result beats, sampled at the rising edge
    always @(posedge clk)
    begin : result_monitor
        line_tokens_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.line_empty   = line_empty;
            seen.name_start   = name_start;
            seen.name_len     = name_len;
            seen.repeat_value = repeat_value;
            seen.op_count     = op_count;
            seen.op_start[0]  = op_a_start;
            seen.op_len[0]    = op_a_len;
            seen.op_start[1]  = op_b_start;
            seen.op_len[1]    = op_b_len;
            seen.op_start[2]  = op_c_start;
            seen.op_len[2]    = op_c_len;
            seen.status       = status;
            tracker.check_line(seen);
        end
    end

    // watchdog: too long with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_beats;
        int line_no;
        int kind;
        int n_ops;
        bit with_rep;

        tracker     = new(LINE_LEN);
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        ch          = '0;
        end_of_line = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed lines
        load_text("");            // stray end beat on a fresh line
        send_line();
        load_text(" \t");         // blanks only
        send_line();
        load_text("[x7");         // empty mnemonic, non-digit first, no ']'
        send_line();
        // one digit then a non-digit, empty operand, extreme bytes
        load_text("ab[1");
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_RBR);
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(8'h00);
        send_line();
        // two digits, empty first operand, three operands and extra text
        load_text("n[42],p,q r");
        send_line();

        // random lines
        random_beats = 0;
        line_no      = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            line_buf.delete();
            // hold the output while lines keep coming, so the queue fills
            if (line_no == 3)
                hold_req = 1'b1;
            // pause the input until every line has been reported
            if (line_no == 8)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0)
                    @(posedge clk);
                @(negedge clk);
            end

            if (line_no == 6)
            begin
                // mnemonic filling the whole line
                repeat (LINE_LEN) line_buf.push_back(pick_word());
            end
            else if (line_no == 10)
            begin
                // overlong line with the bracket never closed
                load_text("ld [");
                repeat (LINE_LEN + 8) line_buf.push_back(pick_digit());
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 10)
                begin
                    // noise, weighted towards the special characters
                    repeat ($urandom_range(0, 16))
                    begin
                        if ($urandom_range(0, 1))
                            line_buf.push_back(8'($urandom));
                        else
                            case ($urandom_range(0, 5))
                                0:       line_buf.push_back(CH_SPACE);
                                1:       line_buf.push_back(CH_TAB);
                                2:       line_buf.push_back(CH_COMMA);
                                3:       line_buf.push_back(CH_LBR);
                                4:       line_buf.push_back(CH_RBR);
                                default: line_buf.push_back(pick_digit());
                            endcase
                    end
                end
                else if (kind < 15)
                begin
                    repeat ($urandom_range(0, 4)) line_buf.push_back(pick_blank());
                end
                else if (kind < 22)
                begin
                    // modifier left open
                    repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
                    repeat ($urandom_range(0, 5)) line_buf.push_back(pick_word());
                    line_buf.push_back(CH_LBR);
                    repeat ($urandom_range(0, 3))
                        line_buf.push_back($urandom_range(0, 1) ? pick_digit() :
                                           8'($urandom_range(8'h61, 8'h7A)));
                end
                else
                begin
                    // well-formed line with random content
                    with_rep = ($urandom_range(0, 2) == 0);
                    repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
                    repeat ($urandom_range(with_rep ? 0 : 1, 8))
                        line_buf.push_back(pick_word());
                    if (with_rep)
                    begin
                        line_buf.push_back(CH_LBR);
                        repeat ($urandom_range(0, 3))
                            line_buf.push_back($urandom_range(0, 4) != 0 ? pick_digit() :
                                               8'($urandom_range(8'h61, 8'h7A)));
                        line_buf.push_back(CH_RBR);
                        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
                    end
                    else
                        repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
                    if ($urandom_range(0, 5) == 0)
                        line_buf.push_back(CH_COMMA);
                    n_ops = $urandom_range(0, 5);
                    for (int k = 0; k < n_ops; k++)
                    begin
                        repeat ($urandom_range(1, 6)) line_buf.push_back(pick_word());
                        if (k < n_ops - 1 || $urandom_range(0, 1))
                            repeat ($urandom_range(1, 3)) line_buf.push_back(pick_sep());
                    end
                end
            end
            random_beats += line_buf.size() + 1;

            send_line();
            line_no++;
            // last stretch runs flat out on both sides
            if (random_beats >= RANDOM_BEATS * 4 / 5)
                idle_on = 1'b0;
        end
        in_valid <= 1'b0;

        // drain, then wait out anything stray
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== asm_line_tokenizer_unit.f =====
sv/altok_pkg.sv
sv/altok_front.sv
sv/altok_fifo.sv
sv/altok_back.sv
sv/asm_line_tokenizer_unit.sv
bench/testbench.sv
